### hw/rtl/qes_pkg.sv
// Package for the quadrature encoder speed block: types, register indexes and reset values.
`default_nettype none

package qes_pkg;

  localparam int unsigned TickWidth     = 32;
  localparam int unsigned LimitWidth    = 16;
  localparam int unsigned StepWidth     = 8;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [1:0] {
    PHASE_NONE = 2'd0,
    PHASE_A    = 2'd1,
    PHASE_B    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DIR_IDLE     = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SLOW_LIMIT   = 3'd0,
    REG_MEDIUM_LIMIT = 3'd1,
    REG_FAST_LIMIT   = 3'd2,
    REG_STEP_SLOW    = 3'd3,
    REG_STEP_MEDIUM  = 3'd4,
    REG_STEP_FAST    = 3'd5,
    REG_STEP_FASTEST = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_t;

  localparam logic [LimitWidth-1:0] SlowLimitReset   = 16'd50;
  localparam logic [LimitWidth-1:0] MediumLimitReset = 16'd35;
  localparam logic [LimitWidth-1:0] FastLimitReset   = 16'd15;
  localparam logic [StepWidth-1:0]  StepSlowReset    = 8'd1;
  localparam logic [StepWidth-1:0]  StepMediumReset  = 8'd3;
  localparam logic [StepWidth-1:0]  StepFastReset    = 8'd5;
  localparam logic [StepWidth-1:0]  StepFastestReset = 8'd10;

  typedef struct packed {
    logic [1:0]           direction;
    logic [StepWidth-1:0] speed_step;
    logic [TickWidth-1:0] interval_ms;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/qes_tick_if.sv
// Channel interface for tick words carrying the raw encoder pin levels.
`default_nettype none

interface qes_tick_if;
  logic valid;
  logic ready;
  logic level_a;
  logic level_b;

  modport source (output valid, output level_a, output level_b, input ready);
  modport sink (input valid, input level_a, input level_b, output ready);
endinterface

`default_nettype wire

### hw/rtl/qes_result_if.sv
// Channel interface for result words: direction, speed step and interval.
`default_nettype none

interface qes_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      direction;
  logic [qes_pkg::StepWidth-1:0]   speed_step;
  logic [qes_pkg::TickWidth-1:0]   interval_ms;

  modport source (output valid, output direction, output speed_step, output interval_ms,
                  input ready);
  modport sink (input valid, input direction, input speed_step, input interval_ms,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/qes_cfg_if.sv
// Channel interface for configuration register writes.
`default_nettype none

interface qes_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qes_pkg::CfgIndexWidth-1:0] index;
  logic [qes_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/quadrature_encoder_speed_top.sv
// Top level of the quadrature encoder decoder with speed step selection.
//
//   channel  modport  word                                    
//   tick     sink     level_a, level_b (active low pin levels)
//   result   source   direction, speed_step, interval_ms      
//   cfg      sink     index, data (register write)            
//
// Each accepted tick word yields one result word, in the result register or, while
// it stalls, in the skid register; a tick is accepted in every cycle while the skid
// is empty. The decode, interval subtraction and three threshold compares sit between
// the encoder state registers and the result register. The skid register keeps
// tick.ready registered; ready falls only while both hold a word. Synchronous reset
// restores config, encoder state and valid flags; cfg writes are always accepted.
`default_nettype none

module quadrature_encoder_speed_top (
  input  wire logic       clk,
  input  wire logic       rst,
  qes_tick_if.sink        tick,
  qes_result_if.source    result,
  qes_cfg_if.sink         cfg
);

  // Configuration registers.
  logic [qes_pkg::LimitWidth-1:0] slow_limit;
  logic [qes_pkg::LimitWidth-1:0] medium_limit;
  logic [qes_pkg::LimitWidth-1:0] fast_limit;
  logic [qes_pkg::StepWidth-1:0]  step_slow;
  logic [qes_pkg::StepWidth-1:0]  step_medium;
  logic [qes_pkg::StepWidth-1:0]  step_fast;
  logic [qes_pkg::StepWidth-1:0]  step_fastest;

  // Encoder state.
  logic [qes_pkg::TickWidth-1:0] tick_count;
  logic [qes_pkg::TickWidth-1:0] last_start_time;
  logic [qes_pkg::TickWidth-1:0] captured_interval;
  qes_pkg::phase_t               phase;
  qes_pkg::dir_t                 latched_direction;

  logic [qes_pkg::TickWidth-1:0] tick_count_next;
  logic [qes_pkg::TickWidth-1:0] last_start_time_next;
  logic [qes_pkg::TickWidth-1:0] captured_interval_next;
  qes_pkg::phase_t               phase_next;
  qes_pkg::dir_t                 latched_direction_next;
  logic [qes_pkg::StepWidth-1:0] speed_step_next;
  qes_pkg::result_t              new_word;

  // Output and skid registers.
  logic             out_valid;
  qes_pkg::result_t out_word;
  logic             skid_valid;
  qes_pkg::result_t skid_word;

  logic a_active;
  logic b_active;
  logic tick_fire;

  assign cfg.ready = 1'b1;
  assign tick.ready = !skid_valid;
  assign tick_fire = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_limit   <= qes_pkg::SlowLimitReset;
      medium_limit <= qes_pkg::MediumLimitReset;
      fast_limit   <= qes_pkg::FastLimitReset;
      step_slow    <= qes_pkg::StepSlowReset;
      step_medium  <= qes_pkg::StepMediumReset;
      step_fast    <= qes_pkg::StepFastReset;
      step_fastest <= qes_pkg::StepFastestReset;
    end else if (cfg.valid) begin
      unique case (qes_pkg::cfg_reg_t'(cfg.index))
        qes_pkg::REG_SLOW_LIMIT:   slow_limit   <= cfg.data;
        qes_pkg::REG_MEDIUM_LIMIT: medium_limit <= cfg.data;
        qes_pkg::REG_FAST_LIMIT:   fast_limit   <= cfg.data;
        qes_pkg::REG_STEP_SLOW:    step_slow    <= cfg.data[qes_pkg::StepWidth-1:0];
        qes_pkg::REG_STEP_MEDIUM:  step_medium  <= cfg.data[qes_pkg::StepWidth-1:0];
        qes_pkg::REG_STEP_FAST:    step_fast    <= cfg.data[qes_pkg::StepWidth-1:0];
        qes_pkg::REG_STEP_FASTEST: step_fastest <= cfg.data[qes_pkg::StepWidth-1:0];
        default: ;
      endcase
    end
  end

  assign a_active = ~tick.level_a;
  assign b_active = ~tick.level_b;

  always_comb begin
    tick_count_next        = tick_count + 32'd1;
    last_start_time_next   = last_start_time;
    captured_interval_next = captured_interval;
    phase_next             = phase;
    latched_direction_next = latched_direction;
    // A detent start captures the interval against the already incremented count.
    unique case ({a_active, b_active})
      2'b00: begin
        phase_next             = qes_pkg::PHASE_NONE;
        latched_direction_next = qes_pkg::DIR_IDLE;
      end
      2'b01: begin
        if (phase == qes_pkg::PHASE_NONE) begin
          phase_next             = qes_pkg::PHASE_A;
          captured_interval_next = tick_count_next - last_start_time;
          last_start_time_next   = tick_count_next;
        end else if (phase == qes_pkg::PHASE_B) begin
          phase_next             = qes_pkg::PHASE_NONE;
          latched_direction_next = qes_pkg::DIR_FORWARD;
        end
      end
      2'b10: begin
        if (phase == qes_pkg::PHASE_NONE) begin
          phase_next             = qes_pkg::PHASE_B;
          captured_interval_next = tick_count_next - last_start_time;
          last_start_time_next   = tick_count_next;
        end else if (phase == qes_pkg::PHASE_A) begin
          phase_next             = qes_pkg::PHASE_NONE;
          latched_direction_next = qes_pkg::DIR_BACKWARD;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (captured_interval_next > {16'd0, slow_limit}) begin
      speed_step_next = step_slow;
    end else if (captured_interval_next > {16'd0, medium_limit}) begin
      speed_step_next = step_medium;
    end else if (captured_interval_next > {16'd0, fast_limit}) begin
      speed_step_next = step_fast;
    end else begin
      speed_step_next = step_fastest;
    end
  end

  always_comb begin
    new_word.direction   = latched_direction_next;
    new_word.speed_step  = speed_step_next;
    new_word.interval_ms = captured_interval_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      last_start_time   <= '0;
      captured_interval <= '0;
      phase             <= qes_pkg::PHASE_NONE;
      latched_direction <= qes_pkg::DIR_IDLE;
    end else if (tick_fire) begin
      tick_count        <= tick_count_next;
      last_start_time   <= last_start_time_next;
      captured_interval <= captured_interval_next;
      phase             <= phase_next;
      latched_direction <= latched_direction_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= tick_fire;
      end
    end else if (tick_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (tick_fire) begin
        out_word <= new_word;
      end
    end else if (tick_fire) begin
      skid_word <= new_word;
    end
  end

  assign result.valid       = out_valid;
  assign result.direction   = out_word.direction;
  assign result.speed_step  = out_word.speed_step;
  assign result.interval_ms = out_word.interval_ms;

endmodule

`default_nettype wire
